@@ rtl/crf_pkg.sv @@
`default_nettype none
package crf_pkg;

	localparam int RAW_W    = 24;
	localparam int VAL_W    = 21;
	localparam int CHAR_W   = 7;
	localparam int LINE_LEN = 10;
	localparam int IDX_W    = $clog2(LINE_LEN);

	localparam int QUEUE_DEPTH_DEF = 2;

	// |raw| * 63 / 4, then / 127 by reciprocal with one correction step
	localparam int             Q_W         = 28;
	localparam int             RECIP_W     = 29;
	localparam int             PROD_W      = Q_W + RECIP_W;
	localparam int             SCALE_SHIFT = 35;
	localparam logic [RECIP_W-1:0] RECIP_127 = 29'd270549120;
	localparam int             SCALE_DIV   = 127;

	// difference modulo 100 by reciprocal
	localparam int             DIFF_W      = 21;
	localparam int             RECIP100_W  = 26;
	localparam int             DPROD_W     = DIFF_W + RECIP100_W;
	localparam int             MOD_SHIFT   = 32;
	localparam logic [RECIP100_W-1:0] RECIP_100 = 26'd42949672;
	localparam int             DIFF_MOD    = 100;
	localparam int             DIFF_LIMIT  = 99;

	localparam int MAG_W   = 17;
	localparam int SAT_MAG = 99999;

	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_E     = 7'h45;
	localparam logic [CHAR_W-1:0] CH_CR    = 7'h0d;

	typedef logic [LINE_LEN-1:0][CHAR_W-1:0] line_t;

	typedef struct packed {
		logic [3:0]       digit;
		logic [MAG_W-1:0] rem;
	} digit_t;

	// one decimal digit of x for a constant place value; x < 10 * place
	function automatic digit_t digit_of(logic [MAG_W-1:0] x, int unsigned place);
		digit_t     r;
		logic [3:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (32'(x) >= 32'(k) * place) begin
				d = 4'(k);
			end
		end
		r.digit = d;
		r.rem   = x - MAG_W'(32'(d) * place);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/crf_in_if.sv @@
`default_nettype none
interface crf_in_if;
	logic                        valid;
	logic                        ready;
	logic [crf_pkg::RAW_W-1:0]   axis0_raw;
	logic [crf_pkg::RAW_W-1:0]   axis1_raw;
	logic [1:0]                  update_mask;

	modport source (output valid, output axis0_raw, output axis1_raw, output update_mask,
		input ready);
	modport sink (input valid, input axis0_raw, input axis1_raw, input update_mask,
		output ready);
endinterface
`default_nettype wire

@@ rtl/crf_out_if.sv @@
`default_nettype none
interface crf_out_if;
	logic                         valid;
	logic                         ready;
	logic [crf_pkg::CHAR_W-1:0]   char_code;
	logic                         last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

@@ rtl/crf_front.sv @@
`default_nettype none
module crf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	crf_in_if.sink             update,
	output logic               push_valid,
	input  wire logic          push_ready,
	output crf_pkg::line_t     push_data
);

	localparam int VAL_W  = crf_pkg::VAL_W;
	localparam int RAW_W  = crf_pkg::RAW_W;
	localparam int Q_W    = crf_pkg::Q_W;
	localparam int PROD_W = crf_pkg::PROD_W;
	localparam int MAG_W  = crf_pkg::MAG_W;
	localparam int DIFF_W = crf_pkg::DIFF_W;
	localparam int DPROD_W = crf_pkg::DPROD_W;
	localparam int EQ_W   = PROD_W - crf_pkg::SCALE_SHIFT;
	localparam int DQ_W   = DPROD_W - crf_pkg::MOD_SHIFT;

	function automatic logic signed [VAL_W-1:0] finish_scale(logic [PROD_W-1:0] p,
		logic [Q_W-1:0] q, logic neg);
		logic [EQ_W-1:0]  e;
		logic [Q_W-1:0]   r;
		logic [VAL_W-1:0] m;
		e = p[PROD_W-1:crf_pkg::SCALE_SHIFT];
		r = q - Q_W'(e) * Q_W'(crf_pkg::SCALE_DIV);
		if (r >= Q_W'(crf_pkg::SCALE_DIV)) begin
			e = e + EQ_W'(1);
		end
		m = e[VAL_W-1:0];
		return neg ? $signed(-m) : $signed(m);
	endfunction

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic signed [VAL_W-1:0] axis0_value_q, axis1_value_q;

	// s1: captured beat
	logic [RAW_W-1:0]  raw_s1 [2];
	logic [1:0]        mask_s1;
	// s2: |raw| * 63 / 4
	logic [Q_W-1:0]    q_s2 [2];
	logic [1:0]        neg_s2;
	logic [1:0]        mask_s2;
	// s3: reciprocal products
	logic [PROD_W-1:0] p_s3 [2];
	logic [Q_W-1:0]    q_s3 [2];
	logic [1:0]        neg_s3;
	logic [1:0]        mask_s3;
	// s4: kept values after update
	logic signed [VAL_W-1:0] v0_s4, v1_s4;
	// s5..s9: formatting
	logic [MAG_W-1:0]  mag0_s5;
	logic [DIFF_W-1:0] dmag_s5, dmag_s6;
	logic [DPROD_W-1:0] dprod_s6;
	logic [6:0]        drem_s7;
	logic              neg0_s5, neg0_s6, neg0_s7, neg0_s8, neg0_s9;
	logic              dneg_s5, dneg_s6, dneg_s7, dneg_s8, dneg_s9;
	logic              derr_s5, derr_s6, derr_s7, derr_s8, derr_s9;
	logic [3:0]        d4_s6, d4_s7, d4_s8, d4_s9;
	logic [3:0]        d3_s7, d3_s8, d3_s9;
	logic [3:0]        d2_s8, d2_s9;
	logic [3:0]        d1_s9, d0_s9;
	logic [13:0]       rem4_s6;
	logic [9:0]        rem3_s7;
	logic [6:0]        rem2_s8;
	logic [3:0]        tens_s8, tens_s9, ones_s8, ones_s9;

	assign en           = !vld_s9 || push_ready;
	assign update.ready = en;
	assign push_valid   = vld_s9;

	logic signed [VAL_W-1:0] nv0, nv1;
	always_comb begin
		nv0 = mask_s3[0] ? finish_scale(p_s3[0], q_s3[0], neg_s3[0]) : axis0_value_q;
		nv1 = mask_s3[1] ? finish_scale(p_s3[1], q_s3[1], neg_s3[1]) : axis1_value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9} <= '0;
			axis0_value_q <= '0;
			axis1_value_q <= '0;
		end else if (en) begin
			vld_s1 <= update.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			if (vld_s3) begin
				axis0_value_q <= nv0;
				axis1_value_q <= nv1;
			end
		end
	end

	logic [RAW_W-1:0]  mag_c [2];
	logic [Q_W+1:0]    m63_c [2];
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag_c[i] = raw_s1[i][RAW_W-1] ? -raw_s1[i] : raw_s1[i];
			m63_c[i] = ((Q_W+2)'(mag_c[i]) << 6) - (Q_W+2)'(mag_c[i]);
		end
	end

	logic [VAL_W-1:0]  av0_c;
	logic [DIFF_W:0]   diff_c, dabs_c;
	logic [DQ_W-1:0]   dq_c;
	logic [DIFF_W-1:0] dr_c;
	crf_pkg::digit_t   dg4_c, dg3_c, dg2_c, dg1_c, dgt_c;
	always_comb begin
		av0_c  = v0_s4[VAL_W-1] ? VAL_W'(-v0_s4) : VAL_W'(v0_s4);
		diff_c = {v0_s4[VAL_W-1], v0_s4} - {v1_s4[VAL_W-1], v1_s4};
		dabs_c = diff_c[DIFF_W] ? -diff_c : diff_c;
		dq_c   = dprod_s6[DPROD_W-1:crf_pkg::MOD_SHIFT];
		dr_c   = dmag_s6 - DIFF_W'(dq_c) * DIFF_W'(crf_pkg::DIFF_MOD);
		if (dr_c >= DIFF_W'(crf_pkg::DIFF_MOD)) begin
			dr_c = dr_c - DIFF_W'(crf_pkg::DIFF_MOD);
		end
		dg4_c = crf_pkg::digit_of(mag0_s5, 10000);
		dg3_c = crf_pkg::digit_of(MAG_W'(rem4_s6), 1000);
		dg2_c = crf_pkg::digit_of(MAG_W'(rem3_s7), 100);
		dg1_c = crf_pkg::digit_of(MAG_W'(rem2_s8), 10);
		dgt_c = crf_pkg::digit_of(MAG_W'(drem_s7), 10);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1[0] <= update.axis0_raw;
			raw_s1[1] <= update.axis1_raw;
			mask_s1   <= update.update_mask;

			for (int i = 0; i < 2; i++) begin
				q_s2[i]   <= m63_c[i][Q_W+1:2];
				neg_s2[i] <= raw_s1[i][RAW_W-1];
				p_s3[i]   <= PROD_W'(q_s2[i]) * PROD_W'(crf_pkg::RECIP_127);
				q_s3[i]   <= q_s2[i];
				neg_s3[i] <= neg_s2[i];
			end
			mask_s2 <= mask_s1;
			mask_s3 <= mask_s2;

			v0_s4 <= nv0;
			v1_s4 <= nv1;

			mag0_s5 <= (av0_c > VAL_W'(crf_pkg::SAT_MAG)) ? MAG_W'(crf_pkg::SAT_MAG)
				: av0_c[MAG_W-1:0];
			neg0_s5 <= v0_s4[VAL_W-1];
			dneg_s5 <= diff_c[DIFF_W];
			dmag_s5 <= dabs_c[DIFF_W-1:0];
			derr_s5 <= dabs_c > (DIFF_W+1)'(crf_pkg::DIFF_LIMIT);

			dprod_s6 <= DPROD_W'(dmag_s5) * DPROD_W'(crf_pkg::RECIP_100);
			dmag_s6  <= dmag_s5;
			d4_s6    <= dg4_c.digit;
			rem4_s6  <= dg4_c.rem[13:0];
			neg0_s6  <= neg0_s5;
			dneg_s6  <= dneg_s5;
			derr_s6  <= derr_s5;

			drem_s7 <= dr_c[6:0];
			d3_s7   <= dg3_c.digit;
			rem3_s7 <= dg3_c.rem[9:0];
			d4_s7   <= d4_s6;
			neg0_s7 <= neg0_s6;
			dneg_s7 <= dneg_s6;
			derr_s7 <= derr_s6;

			tens_s8 <= dgt_c.digit;
			ones_s8 <= dgt_c.rem[3:0];
			d2_s8   <= dg2_c.digit;
			rem2_s8 <= dg2_c.rem[6:0];
			d3_s8   <= d3_s7;
			d4_s8   <= d4_s7;
			neg0_s8 <= neg0_s7;
			dneg_s8 <= dneg_s7;
			derr_s8 <= derr_s7;

			d1_s9   <= dg1_c.digit;
			d0_s9   <= dg1_c.rem[3:0];
			d2_s9   <= d2_s8;
			d3_s9   <= d3_s8;
			d4_s9   <= d4_s8;
			tens_s9 <= tens_s8;
			ones_s9 <= ones_s8;
			neg0_s9 <= neg0_s8;
			dneg_s9 <= dneg_s8;
			derr_s9 <= derr_s8;
		end
	end

	// the minus sign sits left of the first digit shown; in char 2 it is overwritten
	logic shown3, shown4;
	always_comb begin
		shown3 = d4_s9 != 4'd0;
		shown4 = shown3 || (d3_s9 != 4'd0);

		if (derr_s9) begin
			push_data[0] = crf_pkg::CH_E;
		end else if (dneg_s9) begin
			push_data[0] = crf_pkg::CH_MINUS;
		end else begin
			push_data[0] = crf_pkg::CH_SPACE;
		end
		push_data[1] = (tens_s9 != 4'd0) ? crf_pkg::CH_ZERO + 7'(tens_s9) : crf_pkg::CH_SPACE;
		push_data[2] = crf_pkg::CH_ZERO + 7'(ones_s9);
		if (shown3) begin
			push_data[3] = crf_pkg::CH_ZERO + 7'(d4_s9);
		end else if (shown4 && neg0_s9) begin
			push_data[3] = crf_pkg::CH_MINUS;
		end else begin
			push_data[3] = crf_pkg::CH_SPACE;
		end
		if (shown4) begin
			push_data[4] = crf_pkg::CH_ZERO + 7'(d3_s9);
		end else if (neg0_s9) begin
			push_data[4] = crf_pkg::CH_MINUS;
		end else begin
			push_data[4] = crf_pkg::CH_SPACE;
		end
		push_data[5] = crf_pkg::CH_ZERO + 7'(d2_s9);
		push_data[6] = crf_pkg::CH_DOT;
		push_data[7] = crf_pkg::CH_ZERO + 7'(d1_s9);
		push_data[8] = crf_pkg::CH_ZERO + 7'(d0_s9);
		push_data[9] = crf_pkg::CH_CR;
	end

endmodule
`default_nettype wire

@@ rtl/crf_queue.sv @@
`default_nettype none
module crf_queue #(
	parameter int WIDTH = crf_pkg::LINE_LEN * crf_pkg::CHAR_W,
	parameter int DEPTH = crf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/crf_back.sv @@
`default_nettype none
module crf_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire crf_pkg::line_t  pop_data,
	crf_out_if.source            display
);

	localparam int IDX_W = crf_pkg::IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(crf_pkg::LINE_LEN - 1);

	crf_pkg::line_t   line_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             beat, done;

	assign display.valid     = busy_q;
	assign display.char_code = line_q[idx_q];
	assign display.last_char = idx_q == LAST_IDX;

	assign beat      = busy_q && display.ready;
	assign done      = beat && (idx_q == LAST_IDX);
	// next line loads on the carriage return beat, so lines run back to back
	assign pop_ready = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop_valid && pop_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (beat) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			line_q <= pop_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/caliper_readout_formatter.sv @@
// The first character of a line is offered once its update beat has passed nine front
// stages, one queue slot and one load into the character register.
// Sustained throughput is set by the character serializer in the back end; the front
// takes one beat a cycle until the line queue fills.
// Reset (arst_n low, asynchronous): kept axis values go to zero, pipeline, queue
// and serializer are emptied.
`default_nettype none
module caliper_readout_formatter #(
	parameter int QUEUE_DEPTH = crf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	crf_in_if.sink    update,
	crf_out_if.source display
);

	localparam int LINE_W = crf_pkg::LINE_LEN * crf_pkg::CHAR_W;

	logic            push_valid, push_ready;
	crf_pkg::line_t  push_data;
	logic            pop_valid, pop_ready;
	crf_pkg::line_t  pop_data;

	crf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (update),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	crf_queue #(
		.WIDTH (LINE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	crf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.display   (display)
	);

endmodule
`default_nettype wire
